>>> src/assert_macros.svh
// Assertion macros used by the waitlist RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

>>> src/ffw_pkg.sv
// Shared types and constants of the first-fit waitlist.
package ffw_pkg;

  // Name and entry layout
  localparam int unsigned NAME_BYTES = 19;
  localparam int unsigned NAME_W     = 8 * NAME_BYTES;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned QCOUNT_W   = 6;

  // Stream word widths
  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 168;

  typedef logic [NAME_W-1:0] name_t;

  typedef struct packed {
    name_t             name;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Command codes carried on the input tuser
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_SEAT = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_SEATED    = 3'd3,
    ST_NONE_FITS = 3'd4
  } status_e;

endpackage

>>> src/first_fit_waitlist_core.sv
// Top level of the first-fit waitlist: name canonicalizer, sequencer, entry RAM and result register.
// Usage:
//   Input words arrive on s_axis_*. tuser selects add (0) or seat (1); tdata
//   carries the name, the party size and the capacity. Each word yields one
//   result word on m_axis_*: status in tuser, seated name, seated size and the
//   queue count in tdata.
//   An add or a seat that finds nothing walks every queued entry before the
//   result is raised. A seat that removes an entry stops its walk at the
//   hit and then moves every later entry up one place. The next word is
//   taken in the cycle after the result is loaded. The walk is paced by the
//   single read port of the entry RAM, which visits one entry per cycle.
//   s_axis_tready is high only while the sequencer is idle; the next word is
//   taken while a finished result still waits in the output register.
//   If the receiver stalls, the result holds in the output register and a
//   further finished result waits in the sequencer until the register frees.
//   Reset empties the queue at once (the entry count goes to zero); the RAM
//   contents are not cleared and are only read below the entry count.
module first_fit_waitlist_core
  import ffw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned NAME_CHARS  = 19
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: name_low[63:0], name_mid[127:64], name_high[151:128],
  //        party_size[159:152], capacity[167:160]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[0]
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: seated_name_low[63:0], seated_name_mid[127:64],
  //        seated_name_high[151:128], seated_size[159:152],
  //        queue_count[165:160], zero fill[167:166]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

`include "assert_macros.svh"

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cmp_q, cmp_d;
  logic              rvld_q, rvld_d;
  logic              cmd_q, cmd_d;
  name_t             name_q, name_d;
  logic [SIZE_W-1:0] psize_q, psize_d;
  logic [SIZE_W-1:0] cap_q, cap_d;
  status_e           res_status_q, res_status_d;
  name_t             res_name_q, res_name_d;
  logic [SIZE_W-1:0] res_size_q, res_size_d;

  logic              out_vld_q, out_vld_d;
  status_e           out_status_q;
  name_t             out_name_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [QCOUNT_W-1:0] out_count_q;
  logic              out_load;

  name_t             in_name_canon;
  logic              in_accept;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  logic              entry_match;

  // Canonical form of the incoming name
  ffw_canon #(
    .NAME_CHARS (NAME_CHARS)
  ) u_canon (
    .name_i (s_axis_tdata[NAME_W-1:0]),
    .name_o (in_name_canon)
  );

  // Entry storage
  ffw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);
  assign ram_raddr     = idx_q[IDX_W-1:0];

  // Compare the word just read: name for add, size for seat
  assign entry_match = (cmd_q == CMD_ADD) ? (ram_rdata.name == name_q)
                                          : (ram_rdata.size <= cap_q);

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmp_d        = cmp_q;
    rvld_d       = 1'b0;
    cmd_d        = cmd_q;
    name_d       = name_q;
    psize_d      = psize_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_name_d   = res_name_q;
    res_size_d   = res_size_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_wdata    = '{name: name_q, size: psize_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d        = s_axis_tuser;
          name_d       = in_name_canon;
          psize_d      = s_axis_tdata[NAME_W +: SIZE_W];
          cap_d        = s_axis_tdata[NAME_W + SIZE_W +: SIZE_W];
          res_status_d = ST_NONE_FITS;
          res_name_d   = '0;
          res_size_d   = '0;
          idx_d        = '0;
          state_d      = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rvld_q && entry_match) begin
          // First hit ends the walk
          if (cmd_q == CMD_ADD) begin
            res_status_d = ST_DUPLICATE;
            state_d      = S_DONE;
          end else begin
            res_status_d = ST_SEATED;
            res_name_d   = ram_rdata.name;
            res_size_d   = ram_rdata.size;
            idx_d        = cmp_q + 1'b1;
            state_d      = S_SHIFT;
          end
        end else if (idx_q < count_q) begin
          // Issue the next read
          rvld_d = 1'b1;
          cmp_d  = idx_q;
          idx_d  = idx_q + 1'b1;
        end else if (!rvld_q) begin
          // Walked every entry without a hit
          if (cmd_q == CMD_SEAT) begin
            res_status_d = ST_NONE_FITS;
          end else if (count_q == FULL_CNT) begin
            res_status_d = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            count_d      = count_q + 1'b1;
            res_status_d = ST_ADDED;
          end
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        // Move each later entry up one place
        if (rvld_q) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(cmp_q - 1'b1);
          ram_wdata = ram_rdata;
        end
        if (idx_q < count_q) begin
          rvld_d = 1'b1;
          cmp_d  = idx_q;
          idx_d  = idx_q + 1'b1;
        end else if (!rvld_q) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cmp_q        <= cmp_d;
    cmd_q        <= cmd_d;
    name_q       <= name_d;
    psize_q      <= psize_d;
    cap_q        <= cap_d;
    res_status_q <= res_status_d;
    res_name_q   <= res_name_d;
    res_size_q   <= res_size_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_name_q   <= res_name_q;
      out_size_q   <= res_size_q;
      out_count_q  <= QCOUNT_W'(count_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_DATA_W - NAME_W - SIZE_W - QCOUNT_W)'(0),
                          out_count_q, out_size_q, out_name_q};

  // Checks
  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= FULL_CNT,
               "entry count beyond queue depth")
  `ASSERT_NEVER(a_write_when_quiet, clk_i, rst_ni,
                ram_we && (state_q == S_IDLE || state_q == S_DONE),
                "entry RAM written outside scan or shift")
  `ASSERT_PROP(a_seated_fits, clk_i, rst_ni,
               ($rose(out_vld_q) && out_status_q == ST_SEATED) |-> (out_size_q <= cap_q),
               "seated entry larger than capacity")
  `ASSERT_NEVER(a_shift_on_add, clk_i, rst_ni,
                state_q == S_SHIFT && cmd_q == CMD_ADD,
                "compaction started by an add")

endmodule

>>> src/ffw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ffw_canon.sv
// Name canonicalizer: clears every byte from the first zero byte or the length limit on.
module ffw_canon
  import ffw_pkg::*;
#(
  parameter int unsigned NAME_CHARS = 19
) (
  input  name_t name_i,
  output name_t name_o
);

  // Walk the bytes, zero everything past the terminator or the length limit
  always_comb begin
    logic ended;
    logic [7:0] b;
    ended  = 1'b0;
    name_o = '0;
    for (int unsigned i = 0; i < NAME_BYTES; i++) begin
      b = name_i[8*i +: 8];
      if (i >= NAME_CHARS || b == 8'h00) begin
        ended = 1'b1;
      end
      name_o[8*i +: 8] = ended ? 8'h00 : b;
    end
  end

endmodule
